### rtl/cwg_pkg.sv
// cwg_pkg: widths, constants, register indexes, sequencer states and the
// arctangent table shared by the circle waypoint generator files.
// No dependencies.
package cwg_pkg;

    localparam int COORD_W      = 32;
    localparam int INDEX_W      = 6;
    localparam int RADIUS_W     = 10;
    localparam int COUNT_W      = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int ANGLE_W      = 16;
    localparam int CORDIC_W     = 34;
    localparam int PROD_W       = RADIUS_W + 1 + CORDIC_W;
    localparam int SUM_W        = PROD_W + 1;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 32;
    localparam int ROUND_SHIFT  = 14;

    localparam int DEF_MAX_POINTS   = 63;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START_X = 34'sd652032874;
    localparam logic [PROD_W-1:0]          ROUND_BIAS     = PROD_W'(8192);
    localparam logic [RADIUS_W-1:0]        RADIUS_RESET   = 10'd1;
    localparam logic [COUNT_W-1:0]         COUNT_RESET    = 6'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_COUNT  = 2'd1
    } cwg_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORIGIN,
        ST_DIVIDE,
        ST_ROTATE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_EMIT
    } cwg_state_t;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] cwg_atan(input logic [ATAN_IDX_W-1:0] k);
        logic [ATAN_W-1:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/cwg_if.sv
// Valid/ready channel interfaces for the circle waypoint generator:
// origin input, waypoint output and register write port.
// Depends on cwg_pkg.
interface cwg_in_if import cwg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;

    modport source (output valid, origin_x, origin_y, input ready);
    modport sink   (input valid, origin_x, origin_y, output ready);
endinterface

interface cwg_out_if import cwg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic [INDEX_W-1:0]        goal_index;
    logic                      last_goal;

    modport source (output valid, goal_x, goal_y, goal_index, last_goal, input ready);
    modport sink   (input valid, goal_x, goal_y, goal_index, last_goal, output ready);
endinterface

interface cwg_cfg_if import cwg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/circle_waypoint_generator.sv
// Circle waypoint generator top level: sequencer, serial angle divider,
// iterative CORDIC and shared radius multiplier.
// Depends on cwg_pkg and the channel interfaces in cwg_if.sv.

// One origin beat yields the origin itself followed by point_count waypoints
// on a circle of circle_radius around it, the final beat flagged last_goal.
// The block takes one origin at a time and is busy until its final beat has
// been loaded into the output register. The point count is clamped to
// MAX_POINTS. Per point, the sequencer runs the bit-serial divide for the
// 16-bit angle, CORDIC_STEPS rotation steps, the shared radius multiply
// and saturating add, and the output load, which waits out output stalls.
// Register writes are taken at any time and must only be issued while idle.
module circle_waypoint_generator import cwg_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic      clk,
    input  logic      rst_n,
    cwg_cfg_if.sink   cfg,
    cwg_in_if.sink    origin,
    cwg_out_if.source goal
);

    localparam int STEP_W = $clog2((CORDIC_STEPS > ANGLE_W) ? CORDIC_STEPS : ANGLE_W);
    localparam logic [STEP_W-1:0]  DIV_LAST = STEP_W'(ANGLE_W - 1);
    localparam logic [STEP_W-1:0]  ROT_LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [INDEX_W-1:0] N_LIMIT  = INDEX_W'(MAX_POINTS);

    cwg_state_t state_reg, state_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [INDEX_W-1:0]  n_reg, n_next;
    logic [INDEX_W-1:0]  i_reg, i_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                goal_valid_reg, goal_valid_next;

    logic signed [COORD_W-1:0]  ox_reg, ox_next;
    logic signed [COORD_W-1:0]  oy_reg, oy_next;
    logic [RADIUS_W-1:0]        r_reg, r_next;
    logic [INDEX_W-1:0]         rem_reg, rem_next;
    logic [ANGLE_W-1:0]         quot_reg, quot_next;
    logic [1:0]                 quad_reg, quad_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [COORD_W-1:0]  gx_reg, gx_next;
    logic signed [COORD_W-1:0]  gy_reg, gy_next;
    logic signed [COORD_W-1:0]  goal_x_reg, goal_x_next;
    logic signed [COORD_W-1:0]  goal_y_reg, goal_y_next;
    logic [INDEX_W-1:0]         goal_index_reg, goal_index_next;
    logic                       last_goal_reg, last_goal_next;

    logic                       out_free;
    logic                       in_ready;
    logic                       load_beat;
    logic                       point_last;
    logic [INDEX_W-1:0]         i_inc;

    logic [INDEX_W:0]           rem_shift;
    logic                       rem_fits;
    logic [ANGLE_W-1:0]         quot_step;

    logic signed [CORDIC_W-1:0] dx, dy, atan_k;
    logic signed [CORDIC_W-1:0] cos_v, sin_v, mul_op;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [COORD_W-1:0]  add_origin;
    logic signed [SUM_W-1:0]    sum;
    logic [SUM_W-COORD_W:0]     sum_hi;
    logic signed [COORD_W-1:0]  sat_val;

    assign out_free   = !goal_valid_reg || goal.ready;
    assign i_inc      = i_reg + INDEX_W'(1);
    assign point_last = (i_inc == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (origin.valid)
                    state_next = ST_ORIGIN;
            end
            ST_ORIGIN:
            begin
                if (out_free)
                    state_next = (n_reg == '0) ? ST_IDLE : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (step_reg == DIV_LAST)
                    state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (step_reg == ROT_LAST)
                    state_next = ST_MUL_X;
            end
            ST_MUL_X: state_next = ST_MUL_Y;
            ST_MUL_Y: state_next = ST_ADD_Y;
            ST_ADD_Y: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = point_last ? ST_IDLE : ST_DIVIDE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        load_beat = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_ORIGIN: load_beat = out_free;
            ST_EMIT:   load_beat = out_free;
            default:
            begin
                in_ready  = 1'b0;
                load_beat = 1'b0;
            end
        endcase
    end

    assign origin.ready = in_ready;
    assign cfg.ready    = 1'b1;

    // divider step: one quotient bit of (i << 16) / n
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_fits  = (rem_shift >= {1'b0, n_reg});
    assign quot_step = {quot_reg[ANGLE_W-2:0], rem_fits};

    // CORDIC step
    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_k = $signed({{(CORDIC_W-ATAN_W){1'b0}}, cwg_atan(ATAN_IDX_W'(step_reg))});

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = x_reg;
                sin_v = y_reg;
            end
            2'd1:
            begin
                cos_v = -y_reg;
                sin_v = x_reg;
            end
            2'd2:
            begin
                cos_v = -x_reg;
                sin_v = -y_reg;
            end
            default:
            begin
                cos_v = y_reg;
                sin_v = -x_reg;
            end
        endcase
    end

    // shared multiplier and round/add/saturate
    assign mul_op     = (state_reg == ST_MUL_X) ? cos_v : sin_v;
    assign rounded    = (prod_reg + $signed(ROUND_BIAS)) >>> ROUND_SHIFT;
    assign add_origin = (state_reg == ST_MUL_Y) ? ox_reg : oy_reg;
    assign sum        = SUM_W'(add_origin) + SUM_W'(rounded);
    assign sum_hi     = sum[SUM_W-1:COORD_W-1];

    always_comb
    begin
        if ((&sum_hi) || !(|sum_hi))
            sat_val = sum[COORD_W-1:0];
        else if (sum[SUM_W-1])
            sat_val = {1'b1, {(COORD_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(COORD_W-1){1'b1}}};
    end

    // datapath next values
    always_comb
    begin
        n_next          = n_reg;
        i_next          = i_reg;
        step_next       = step_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        r_next          = r_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        quad_next       = quad_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        prod_next       = prod_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        goal_index_next = goal_index_reg;
        last_goal_next  = last_goal_reg;
        goal_valid_next = goal_valid_reg && !goal.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (origin.valid)
                begin
                    ox_next = origin.origin_x;
                    oy_next = origin.origin_y;
                    n_next  = (count_reg > N_LIMIT) ? N_LIMIT : count_reg;
                    r_next  = radius_reg;
                    i_next  = '0;
                end
            end
            ST_ORIGIN:
            begin
                if (out_free)
                begin
                    goal_x_next     = ox_reg;
                    goal_y_next     = oy_reg;
                    goal_index_next = '0;
                    last_goal_next  = (n_reg == '0);
                    rem_next        = i_reg;
                    quot_next       = '0;
                    step_next       = '0;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = rem_fits ? INDEX_W'(rem_shift - {1'b0, n_reg})
                                     : rem_shift[INDEX_W-1:0];
                quot_next = quot_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                begin
                    quad_next = quot_step[ANGLE_W-1:ANGLE_W-2];
                    z_next    = $signed({{(CORDIC_W-ANGLE_W-ANGLE_W+2){1'b0}},
                                         quot_step[ANGLE_W-3:0], {ANGLE_W{1'b0}}});
                    x_next    = CORDIC_START_X;
                    y_next    = '0;
                    step_next = '0;
                end
            end
            ST_ROTATE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (!z_reg[CORDIC_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_k;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_k;
                end
            end
            ST_MUL_X:
            begin
                prod_next = $signed({1'b0, r_reg}) * mul_op;
            end
            ST_MUL_Y:
            begin
                prod_next = $signed({1'b0, r_reg}) * mul_op;
                gx_next   = sat_val;
            end
            ST_ADD_Y:
            begin
                gy_next = sat_val;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    goal_x_next     = gx_reg;
                    goal_y_next     = gy_reg;
                    goal_index_next = i_inc;
                    last_goal_next  = point_last;
                    i_next          = i_inc;
                    rem_next        = i_inc;
                    quot_next       = '0;
                    step_next       = '0;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase

        if (load_beat)
            goal_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            goal_valid_reg <= 1'b0;
            radius_reg     <= RADIUS_RESET;
            count_reg      <= COUNT_RESET;
            n_reg          <= '0;
            i_reg          <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            goal_valid_reg <= goal_valid_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            step_reg       <= step_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_RADIUS: radius_reg <= cfg.data[RADIUS_W-1:0];
                    REG_COUNT:  count_reg  <= cfg.data[COUNT_W-1:0];
                    default:    radius_reg <= radius_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        r_reg          <= r_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        quad_reg       <= quad_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        prod_reg       <= prod_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        goal_x_reg     <= goal_x_next;
        goal_y_reg     <= goal_y_next;
        goal_index_reg <= goal_index_next;
        last_goal_reg  <= last_goal_next;
    end

    assign goal.valid      = goal_valid_reg;
    assign goal.goal_x     = goal_x_reg;
    assign goal.goal_y     = goal_y_reg;
    assign goal.goal_index = goal_index_reg;
    assign goal.last_goal  = last_goal_reg;

endmodule

### rtl/cwg_checker.sv
// Port-level checks for the circle waypoint generator, bound to the top.
// Depends on cwg_pkg and circle_waypoint_generator.
module cwg_checker import cwg_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [COORD_W-1:0]  goal_x,
    input logic [COORD_W-1:0]  goal_y,
    input logic [INDEX_W-1:0]  goal_index,
    input logic                last_goal
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(goal_x) && $stable(goal_y)
            && $stable(goal_index) && $stable(last_goal))
        else $error("stalled waypoint beat changed");

    // one origin at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("origin taken while busy");

    // run not finished while a non-final beat waits
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_goal |-> !in_ready)
        else $error("ready for an origin before the run ended");

    // waypoints after the origin beat carry a non-zero index
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_goal |=> !out_valid || (goal_index != '0))
        else $error("waypoint index went back to zero inside a run");

endmodule

bind circle_waypoint_generator cwg_checker u_cwg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (origin.valid),
    .in_ready   (origin.ready),
    .out_valid  (goal.valid),
    .out_ready  (goal.ready),
    .goal_x     (goal.goal_x),
    .goal_y     (goal.goal_y),
    .goal_index (goal.goal_index),
    .last_goal  (goal.last_goal)
);
